// ===== rtl/core/sabf_pkg.sv =====
package sabf_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned BucketWays   = 4;

  typedef enum logic [1:0] {
    REQ_BYTE   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CLS_RUNT  = 2'd0,
    CLS_IPV4  = 2'd1,
    CLS_IPV6  = 2'd2,
    CLS_OTHER = 2'd3
  } class_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_OUT
  } state_e;

  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [15:0] EthIpv6 = 16'h86dd;

  // Lookup request from the parser to the table.
  typedef struct packed {
    logic         valid;
    logic [1:0]   kind;   // req_e
    logic [127:0] key;
    logic [31:0]  action;
    logic [1:0]   cls;
  } lookup_t;

endpackage

// ===== rtl/core/sabf_parser.sv =====
module sabf_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [1:0]            req_type_i,
  input  logic [7:0]            frame_byte_i,
  input  logic                  frame_last_i,
  input  logic [63:0]           key_high_i,
  input  logic [63:0]           key_low_i,
  input  logic [31:0]           entry_action_i,
  output sabf_pkg::lookup_t     lookup_o
);
  import sabf_pkg::*;

  logic [15:0]  pos_q;
  logic [15:0]  ety_q;
  logic [127:0] addr_q;
  logic [127:0] addr_now;
  logic [15:0]  ety_now;
  logic [16:0]  len;
  logic [1:0]   cls;
  logic [127:0] key4;

  // Capture of ethertype and address bytes including the current byte
  always_comb begin
    addr_now = addr_q;
    ety_now  = ety_q;
    if (pos_q == 16'd12) ety_now[15:8] = frame_byte_i;
    else if (pos_q == 16'd13) ety_now[7:0] = frame_byte_i;
    else if (pos_q >= 16'd22 && pos_q <= 16'd37)
      addr_now[8'(8'd127 - 8'((pos_q[7:0] - 8'd22) * 8'd8)) -: 8] = frame_byte_i;
    len = {1'b0, pos_q} + 17'd1;
    if (len < 17'd14) cls = CLS_RUNT;
    else if (ety_now == EthIpv4 && len >= 17'd34) cls = CLS_IPV4;
    else if (ety_now == EthIpv6 && len >= 17'd54) cls = CLS_IPV6;
    else cls = CLS_OTHER;
    key4 = {64'd0, 32'h0000ffff, addr_now[95:64]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      ety_q  <= '0;
      addr_q <= '0;
    end else if (take_i && req_type_i == REQ_BYTE) begin
      if (frame_last_i) begin
        pos_q  <= '0;
        ety_q  <= '0;
        addr_q <= '0;
      end else begin
        if (pos_q != 16'hffff) pos_q <= pos_q + 16'd1;
        ety_q  <= ety_now;
        addr_q <= addr_now;
      end
    end
  end

  // Request toward the table
  always_comb begin
    lookup_o.valid  = take_i && (req_type_i != REQ_NONE) &&
                      (req_type_i != REQ_BYTE || frame_last_i);
    lookup_o.kind   = req_type_i;
    lookup_o.action = entry_action_i;
    lookup_o.cls    = (req_type_i == REQ_BYTE) ? cls : CLS_RUNT;
    if (req_type_i != REQ_BYTE) lookup_o.key = {key_high_i, key_low_i};
    else if (cls == CLS_IPV4)   lookup_o.key = key4;
    else                        lookup_o.key = addr_now;
  end

endmodule

// ===== rtl/core/sabf_table.sv =====
module sabf_table #(
  parameter int unsigned TABLE_ENTRIES = sabf_pkg::TableEntries,
  parameter int unsigned BUCKET_WAYS   = sabf_pkg::BucketWays
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sabf_pkg::lookup_t lookup_i,
  input  logic              out_stall_i,
  output logic              busy_o,
  output logic              out_valid_o,
  output logic              result_kind_o,
  output logic              drop_frame_o,
  output logic              key_matched_o,
  output logic [1:0]        frame_class_o,
  output logic [1:0]        status_o
);
  import sabf_pkg::*;

  localparam int unsigned Buckets = TABLE_ENTRIES / BUCKET_WAYS;
  localparam int unsigned BkW     = (Buckets > 1) ? $clog2(Buckets) : 1;
  // floor(log2(Buckets))
  localparam int unsigned FoldK   = $clog2(Buckets + 1) - 1;
  localparam int unsigned RowW    = 1 + 128 + 32;
  localparam int unsigned FposW   = $clog2(BkW + 1);

  // One row per bucket: each way holds valid, key and action.
  logic [BUCKET_WAYS*RowW-1:0] mem [Buckets];
  logic [BUCKET_WAYS*RowW-1:0] rd_q;
  logic [BUCKET_WAYS*RowW-1:0] wr_row;

  state_e      state_q, state_d;
  logic [BkW-1:0] clr_q;
  lookup_t     req_q;
  logic [BkW-1:0] bk_q;
  logic [BkW-1:0] bucket;
  logic [BkW:0]   fold;
  logic        we;
  logic [BkW-1:0] waddr;

  logic        hit;
  logic [31:0] hit_action;
  logic [$clog2(BUCKET_WAYS+1)-1:0] hit_way, free_way;
  logic        has_free;
  logic [1:0]  st;
  logic        drop, matched;

  logic        res_kind_q, drop_q, match_q;
  logic [1:0]  cls_q, st_q;

  // XOR fold of the key over the bucket index bits, reduced below Buckets
  always_comb begin
    logic [FposW-1:0] fpos;
    fold = '0;
    fpos = '0;
    if (FoldK > 0) begin
      for (int i = 0; i < 128; i++) begin
        fold[fpos] ^= lookup_i.key[i];
        fpos = (fpos == FposW'(FoldK - 1)) ? '0 : fpos + 1'b1;
      end
    end
    if (fold >= (BkW+1)'(Buckets)) fold = fold - (BkW+1)'(Buckets);
    bucket = fold[BkW-1:0];
  end

  // Way compare across the bucket row
  always_comb begin
    hit = 1'b0; hit_way = '0; hit_action = '0;
    has_free = 1'b0; free_way = '0;
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (rd_q[w*RowW + RowW-1] && rd_q[w*RowW+32 +: 128] == req_q.key) begin
        hit = 1'b1; hit_way = ($bits(hit_way))'(w);
        hit_action = rd_q[w*RowW +: 32];
      end
      if (!rd_q[w*RowW + RowW-1]) begin
        has_free = 1'b1; free_way = ($bits(free_way))'(w);
      end
    end
    wr_row = rd_q;
    st = ST_OK;
    we = 1'b0;
    drop = 1'b0; matched = 1'b0;
    case (req_q.kind)
      REQ_WRITE: begin
        if (hit) begin
          wr_row[hit_way*RowW +: 32] = req_q.action;
          we = 1'b1;
        end else if (has_free) begin
          wr_row[free_way*RowW +: RowW] = {1'b1, req_q.key, req_q.action};
          we = 1'b1;
        end else st = ST_FULL;
      end
      REQ_DELETE: begin
        if (hit) begin
          wr_row[hit_way*RowW + RowW-1] = 1'b0;
          we = 1'b1;
        end else st = ST_NOTFOUND;
      end
      default: begin
        if (req_q.cls == CLS_IPV4 || req_q.cls == CLS_IPV6) begin
          matched = hit;
          drop = hit && hit_action == 32'd1;
        end
      end
    endcase
  end

  // Sequencer: clear sweep, then read, compare/write back, present
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_q == BkW'(Buckets - 1)) state_d = S_IDLE;
      S_IDLE:   if (lookup_i.valid) state_d = S_LOOKUP;
      S_LOOKUP: state_d = S_OUT;
      S_OUT:    if (!out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && lookup_i.valid) begin
      req_q <= lookup_i;
      bk_q <= bucket;
    end
    if (state_q == S_LOOKUP) begin
      res_kind_q <= (req_q.kind != REQ_BYTE);
      drop_q <= drop; match_q <= matched;
      cls_q <= req_q.cls; st_q <= st;
    end
  end

  // Bucket memory: one read and one write port
  assign waddr = (state_q == S_CLEAR) ? clr_q : bk_q;
  always_ff @(posedge clk_i) begin
    rd_q <= mem[bucket];
    if (state_q == S_CLEAR) mem[waddr] <= '0;
    else if (state_q == S_LOOKUP && we) mem[waddr] <= wr_row;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign result_kind_o = res_kind_q;
  assign drop_frame_o  = drop_q;
  assign key_matched_o = match_q;
  assign frame_class_o = cls_q;
  assign status_o      = st_q;

endmodule

// ===== rtl/core/source_address_blocklist_filter.sv =====
// Source address blocklist filter.
// Input channel: in_valid_i / in_stall_o with req_type, frame byte, last flag,
// key and action. Frame bytes stream one per cycle unless stalled; a table
// write or delete is one transfer. Output channel: out_valid_o / out_stall_i,
// one result per last byte (verdict) or table request (status); other bytes
// give none. A result is registered after the memory read and compare.
// Throughput: non-final bytes are taken every cycle while the table is idle;
// a final byte or a table request stalls the input through its memory read,
// compare and write back, and result transfer, so the next transfer waits
// until the result is taken, longer while the receiver stalls.
// The table is one bucket-wide memory row: all ways are read and compared
// in parallel, and modified rows are written back in the compare cycle.
// After reset a clearing pass walks all TABLE_ENTRIES/BUCKET_WAYS rows, one
// per cycle, with in_stall_o high; the frame state is cleared at once.
// A stalled result holds its fields and keeps the input stalled.
module source_address_blocklist_filter #(
  parameter int unsigned TABLE_ENTRIES = sabf_pkg::TableEntries,
  parameter int unsigned BUCKET_WAYS   = sabf_pkg::BucketWays
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_last_i,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_low_i,
  input  logic [31:0] entry_action_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic        drop_frame_o,
  output logic        key_matched_o,
  output logic [1:0]  frame_class_o,
  output logic [1:0]  status_o
);
  import sabf_pkg::*;

  logic    busy;
  logic    take;
  lookup_t lookup;

  assign in_stall_o = busy;
  assign take = in_valid_i && !busy;

  sabf_parser u_parser (
    .clk_i, .rst_ni, .take_i(take), .req_type_i, .frame_byte_i, .frame_last_i,
    .key_high_i, .key_low_i, .entry_action_i, .lookup_o(lookup)
  );

  sabf_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .BUCKET_WAYS(BUCKET_WAYS)) u_table (
    .clk_i, .rst_ni, .lookup_i(lookup), .out_stall_i, .busy_o(busy),
    .out_valid_o, .result_kind_o, .drop_frame_o, .key_matched_o,
    .frame_class_o, .status_o
  );

  // A result only ever follows a lookup-starting transfer
  a_res_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(lookup.valid, 2)) else $error("orphan result");
  // Nothing is accepted while a result is pending
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !take) else $error("transfer while result pending");
  // A table status never carries a verdict
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o) |-> !drop_frame_o && !key_matched_o)
    else $error("status result with verdict bits");

endmodule

// ===== test/tb_source_address_blocklist_filter.sv =====
module tb_source_address_blocklist_filter;
  import sabf_pkg::*;

  localparam int unsigned BucketCount = TableEntries / BucketWays;
  localparam int unsigned IndexBits   = $clog2(BucketCount);

  typedef struct packed {
    logic       kind;
    logic       drop;
    logic       matched;
    logic [1:0] cls;
    logic [1:0] status;
  } verdict_t;

  // Filter predictor: frame parser state plus a copy of the table
  class filter_scoreboard;
    logic [15:0]  byte_cnt;
    logic [15:0]  ethertype;
    logic [7:0]   addr_bytes [16];
    logic [63:0]  tbl_hi     [TableEntries];
    logic [63:0]  tbl_lo     [TableEntries];
    logic [31:0]  tbl_act    [TableEntries];
    bit           tbl_vld    [TableEntries];
    verdict_t     pending_q  [$];
    int           errors;

    function new();
      byte_cnt  = '0;
      ethertype = '0;
      foreach (addr_bytes[i]) addr_bytes[i] = '0;
      foreach (tbl_vld[i]) tbl_vld[i] = 1'b0;
      errors = 0;
    endfunction

    function int unsigned bucket(logic [127:0] key);
      logic [IndexBits-1:0] b;
      b = '0;
      for (int i = 0; i < 128; i++) b[i % IndexBits] ^= key[i];
      return int'(b) % BucketCount;
    endfunction

    function int find(logic [127:0] key);
      int unsigned base;
      base = bucket(key) * BucketWays;
      for (int w = 0; w < BucketWays; w++)
        if (tbl_vld[base+w] && {tbl_hi[base+w], tbl_lo[base+w]} == key) return base + w;
      return -1;
    endfunction

    // Note one accepted input transfer, queue its verdict if it has one
    function void note_input(req_e req, logic [7:0] b, logic last,
                             logic [127:0] key, logic [31:0] act);
      verdict_t     v;
      int           e;
      int unsigned  base;
      int unsigned  len;
      logic [127:0] fkey;
      v = '0;
      if (req == REQ_NONE) return;
      if (req != REQ_BYTE) begin
        e = find(key);
        v.kind = 1'b1;
        v.status = ST_OK;
        if (req == REQ_WRITE) begin
          if (e >= 0) tbl_act[e] = act;
          else begin
            base = bucket(key) * BucketWays;
            v.status = ST_FULL;
            for (int w = 0; w < BucketWays; w++)
              if (!tbl_vld[base+w]) begin
                tbl_vld[base+w] = 1'b1;
                {tbl_hi[base+w], tbl_lo[base+w]} = key;
                tbl_act[base+w] = act;
                v.status = ST_OK;
                break;
              end
          end
        end else begin
          if (e >= 0) tbl_vld[e] = 1'b0;
          else v.status = ST_NOTFOUND;
        end
        pending_q.push_back(v);
        return;
      end
      len = byte_cnt + 1;
      if (byte_cnt == 12) ethertype[15:8] = b;
      else if (byte_cnt == 13) ethertype[7:0] = b;
      else if (byte_cnt >= 22 && byte_cnt <= 37) addr_bytes[byte_cnt-22] = b;
      if (byte_cnt != 16'hffff) byte_cnt++;
      if (!last) return;
      if (len < 14) v.cls = CLS_RUNT;
      else if (ethertype == EthIpv4 && len >= 34) v.cls = CLS_IPV4;
      else if (ethertype == EthIpv6 && len >= 54) v.cls = CLS_IPV6;
      else v.cls = CLS_OTHER;
      if (v.cls == CLS_IPV4 || v.cls == CLS_IPV6) begin
        if (v.cls == CLS_IPV4)
          fkey = {80'h0, 16'hffff, addr_bytes[4], addr_bytes[5], addr_bytes[6], addr_bytes[7]};
        else
          for (int i = 0; i < 16; i++) fkey[127-8*i -: 8] = addr_bytes[i];
        e = find(fkey);
        if (e >= 0) begin
          v.matched = 1'b1;
          v.drop = (tbl_act[e] == 32'd1);
        end
      end
      byte_cnt = '0;
      ethertype = '0;
      foreach (addr_bytes[i]) addr_bytes[i] = '0;
      pending_q.push_back(v);
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(verdict_t got);
      verdict_t exp;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp = pending_q.pop_front();
      if (got.kind != exp.kind)
        report($sformatf("result_kind %0d exp %0d", got.kind, exp.kind));
      if (got.drop != exp.drop)
        report($sformatf("drop_frame %0d exp %0d", got.drop, exp.drop));
      if (got.matched != exp.matched)
        report($sformatf("key_matched %0d exp %0d", got.matched, exp.matched));
      if (got.cls != exp.cls)
        report($sformatf("frame_class %0d exp %0d", got.cls, exp.cls));
      if (got.status != exp.status)
        report($sformatf("status %0d exp %0d", got.status, exp.status));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = REQ_BYTE;
  logic [7:0]  frame_byte_i = '0;
  logic        frame_last_i = 1'b0;
  logic [63:0] key_high_i = '0;
  logic [63:0] key_low_i = '0;
  logic [31:0] entry_action_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o, drop_frame_o, key_matched_o;
  logic [1:0]  frame_class_o, status_o;

  filter_scoreboard sb;
  bit               quiet;
  int               sent;
  logic [127:0]     known_keys [$];

  source_address_blocklist_filter i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_input(req_e'(req_type_i), frame_byte_i, frame_last_i,
                      {key_high_i, key_low_i}, entry_action_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result({result_kind_o, drop_frame_o, key_matched_o,
                         frame_class_o, status_o});
    end
  end

  // Receiver stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Drive one transfer and hold it until accepted; valid stays up for the next one
  task automatic send(req_e req, logic [7:0] b, logic last, logic [127:0] key,
                      logic [31:0] act);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    frame_byte_i   <= b;
    frame_last_i   <= last;
    {key_high_i, key_low_i} <= key;
    entry_action_i <= act;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic table_req(req_e req, logic [127:0] key, logic [31:0] act);
    send(req, 8'($urandom), 1'($urandom), key, act);
  endtask

  // Send a frame; kind 1 IPv4, 2 IPv6, else random ethertype
  task automatic send_frame(int unsigned len, int kind, logic [127:0] key);
    logic [7:0] b;
    for (int unsigned p = 0; p < len; p++) begin
      b = 8'($urandom);
      if (kind == 1 && p == 12) b = 8'h08;
      if (kind == 1 && p == 13) b = 8'h00;
      if (kind == 2 && p == 12) b = 8'h86;
      if (kind == 2 && p == 13) b = 8'hdd;
      if (kind == 1 && p >= 26 && p <= 29) b = key[31-8*(p-26) -: 8];
      if (kind == 2 && p >= 22 && p <= 37) b = key[127-8*(p-22) -: 8];
      send(REQ_BYTE, b, p == len - 1, {$urandom, $urandom, $urandom, $urandom},
           $urandom);
    end
  endtask

  function automatic logic [127:0] rand_key(bit v4);
    logic [127:0] k;
    k = {$urandom, $urandom, $urandom, $urandom};
    if (v4) k[127:32] = {80'h0, 16'hffff};
    return k;
  endfunction

  function automatic logic [127:0] pick_key();
    if (known_keys.size() == 0 || $urandom_range(0, 3) == 0)
      return rand_key(1'($urandom_range(0, 1)));
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // Watchdog
  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [127:0] k;
    logic [127:0] same [5];
    int           n;
    sb = new();
    quiet = 1'b0;
    sent = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, full bucket, delete miss, runts, short IP frames
    k = rand_key(1);
    known_keys.push_back(k);
    table_req(REQ_DELETE, k, 32'd1);
    table_req(REQ_WRITE, k, 32'd1);
    send_frame(34, 1, k);
    table_req(REQ_WRITE, k, 32'hffff_ffff);
    send_frame(34, 1, k);
    send_frame(33, 1, k);
    send_frame(1, 0, '0);
    send_frame(13, 0, '0);
    send_frame(14, 0, '0);
    k = '1;
    known_keys.push_back(k);
    table_req(REQ_WRITE, k, 32'd1);
    send_frame(54, 2, k);
    send_frame(53, 2, k);
    table_req(REQ_WRITE, '0, 32'd0);
    known_keys.push_back('0);
    send_frame(54, 2, '0);
    // keys differing in index-bit multiples fold to one bucket
    for (int i = 0; i < 5; i++) begin
      same[i] = '0;
      same[i][IndexBits*(i+1)] = 1'b1;
      same[i][IndexBits*(i+2)] = 1'b1;
    end
    for (int i = 0; i < 5; i++) table_req(REQ_WRITE, same[i], 32'd1);
    table_req(REQ_DELETE, same[0], 32'd0);
    table_req(REQ_WRITE, same[4], 32'd1);
    send(REQ_NONE, '1, 1'b1, '1, '1);
    // table request in the middle of a frame
    send(REQ_BYTE, 8'h00, 1'b0, '0, '0);
    table_req(REQ_DELETE, same[1], 32'd0);
    send(REQ_BYTE, 8'hff, 1'b1, '0, '0);

    // Random: mostly well-formed IP frames against known keys
    while (sent < 400) begin
      if (sent > 340) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1: begin
          k = rand_key(1'($urandom_range(0, 1)));
          known_keys.push_back(k);
          table_req(REQ_WRITE, k, $urandom_range(0, 2) == 0 ? $urandom : 32'd1);
        end
        2: begin
          table_req(REQ_DELETE, pick_key(), $urandom);
        end
        3: begin
          send(REQ_NONE, 8'($urandom), 1'($urandom), pick_key(), $urandom);
        end
        4: begin
          send_frame($urandom_range(1, 60), $urandom_range(0, 2), pick_key());
        end
        5, 6: begin
          send_frame($urandom_range(34, 48), 1, pick_key());
        end
        default: begin
          send_frame($urandom_range(54, 70), 2, pick_key());
        end
      endcase
    end
    // one last frame with a random ethertype
    send_frame(40, 3, '0);
    in_valid_i <= 1'b0;

    n = 0;
    while (sb.pending_q.size() != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
